@@ src/stability_timeout_assist_fsm_defines.svh @@
// ----------------------------------------------------------------------------
// Stability timeout assist FSM assertion macros
// Shared concurrent assertion wrappers for the supervisor checkers.
// ----------------------------------------------------------------------------
`ifndef STABILITY_TIMEOUT_ASSIST_FSM_DEFINES_SVH
`define STABILITY_TIMEOUT_ASSIST_FSM_DEFINES_SVH

// Check on every rising edge, skip while reset is asserted.
`define STAFSM_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define STAFSM_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

@@ src/stafsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Stability timeout assist FSM package
// Types, register codes and configuration check shared by the supervisor.
// ----------------------------------------------------------------------------
package stafsm_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_START         = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK          = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FORCE_RELEASE = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_REQUIRED = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ASSIST_ON       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ASSIST_HOLD     = 8'd3;

    typedef enum logic [1:0] {
        PH_DISABLED = 2'd0,
        PH_ARMED    = 2'd1,
        PH_HELD     = 2'd2,
        PH_RELEASED = 2'd3
    } assist_phase_t;

    typedef enum logic [1:0] {
        VERDICT_ACTIVE    = 2'd0,
        VERDICT_SATISFIED = 2'd1,
        VERDICT_TIMED_OUT = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [TIME_W-1:0] timeout_limit;
        logic [TIME_W-1:0] stable_required;
        logic              assist_on;
        logic [TIME_W-1:0] assist_hold;
    } cfg_t;

    typedef struct packed {
        logic                armed;
        logic [TIME_W-1:0]   start_stamp;
        assist_phase_t       assist_phase;
        verdict_t            verdict;
        logic                steady_active;
        logic [TIME_W-1:0]   steady_start_stamp;
        logic [TIME_W-1:0]   steady_elapsed;
        logic [TIME_W-1:0]   press_stamp;
    } sup_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] now_time;
        logic              goal_met;
        logic              assist_wanted;
    } item_t;

    typedef struct packed {
        logic              bad_setup;
        logic              done_ok;
        logic              expired;
        logic [TIME_W-1:0] steady_time;
        logic              steady_began;
        logic              steady_lost;
        logic              press_now;
        logic              release_now;
        logic              assist_held_now;
        logic              assist_ever_used;
        logic              forced_release_done;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        timeout_limit:   32'd10000,
        stable_required: 32'd500,
        assist_on:       1'b0,
        assist_hold:     32'd0
    };

    localparam sup_state_t SUP_STATE_CLEAR = '{
        armed:              1'b0,
        start_stamp:        '0,
        assist_phase:       PH_DISABLED,
        verdict:            VERDICT_ACTIVE,
        steady_active:      1'b0,
        steady_start_stamp: '0,
        steady_elapsed:     '0,
        press_stamp:        '0
    };

    function automatic logic cfg_is_valid(input cfg_t c);
        logic ok;
        begin
            ok = (c.timeout_limit != '0) && (c.stable_required < c.timeout_limit);
            if (c.assist_on)
            begin
                ok = ok && (c.stable_required != '0) && (c.assist_hold != '0)
                     && (c.assist_hold < c.timeout_limit);
            end
            else
            begin
                ok = ok && (c.assist_hold == '0);
            end
            return ok;
        end
    endfunction

endpackage

@@ src/stafsm_intf.sv @@
// ----------------------------------------------------------------------------
// Stability timeout assist FSM channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface stafsm_item_if;
    import stafsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] now_time;
    logic              goal_met;
    logic              assist_wanted;

    modport source (output valid, kind, now_time, goal_met, assist_wanted, input ready);
    modport sink   (input valid, kind, now_time, goal_met, assist_wanted, output ready);
endinterface

interface stafsm_result_if;
    import stafsm_pkg::*;

    logic              valid;
    logic              ready;
    logic              bad_setup;
    logic              done_ok;
    logic              expired;
    logic [TIME_W-1:0] steady_time;
    logic              steady_began;
    logic              steady_lost;
    logic              press_now;
    logic              release_now;
    logic              assist_held_now;
    logic              assist_ever_used;
    logic              forced_release_done;

    modport source (
        output valid, bad_setup, done_ok, expired, steady_time, steady_began, steady_lost,
               press_now, release_now, assist_held_now, assist_ever_used,
               forced_release_done,
        input  ready
    );
    modport sink (
        input  valid, bad_setup, done_ok, expired, steady_time, steady_began, steady_lost,
               press_now, release_now, assist_held_now, assist_ever_used,
               forced_release_done,
        output ready
    );
endinterface

interface stafsm_cfg_if;
    import stafsm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/stafsm_step.sv @@
// ----------------------------------------------------------------------------
// Stability timeout assist FSM step
// Next state and result for one item, from the stored supervisor state.
// ----------------------------------------------------------------------------
module stafsm_step (
    input  stafsm_pkg::sup_state_t st,
    input  stafsm_pkg::cfg_t       cfg_val,
    input  logic                   cfg_ok,
    input  stafsm_pkg::item_t      itm,
    output stafsm_pkg::sup_state_t st_next,
    output stafsm_pkg::result_t    res
);
    import stafsm_pkg::*;

    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_steady;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] run_elapsed;

    // All differences wrap modulo 2^32
    assign since_start  = itm.now_time - st.start_stamp;
    assign since_steady = itm.now_time - st.steady_start_stamp;
    assign since_press  = itm.now_time - st.press_stamp;
    assign run_elapsed  = st.steady_active ? since_steady : st.steady_elapsed;

    always_comb
    begin
        st_next = st;
        res     = '0;

        unique case (itm.kind)
            KIND_START:
            begin
                st_next = SUP_STATE_CLEAR;
                if (cfg_ok)
                begin
                    st_next.armed        = 1'b1;
                    st_next.start_stamp  = itm.now_time;
                    st_next.assist_phase = cfg_val.assist_on ? PH_ARMED : PH_DISABLED;
                end
            end

            KIND_TICK:
            begin
                if (!st.armed || !cfg_ok)
                begin
                    res.bad_setup = 1'b1;
                end
                else
                begin
                    unique case (st.verdict)
                        VERDICT_SATISFIED:
                        begin
                            res.done_ok     = 1'b1;
                            res.steady_time = st.steady_elapsed;
                        end

                        VERDICT_TIMED_OUT:
                        begin
                            res.expired     = 1'b1;
                            res.steady_time = st.steady_elapsed;
                        end

                        VERDICT_ACTIVE:
                        begin
                            if (since_start >= cfg_val.timeout_limit)
                            begin
                                // Deadline reached: refresh elapsed, drop a held press
                                st_next.steady_elapsed = run_elapsed;
                                res.steady_time        = run_elapsed;
                                if (st.assist_phase == PH_HELD)
                                begin
                                    st_next.assist_phase = PH_RELEASED;
                                    res.release_now      = 1'b1;
                                end
                                st_next.verdict = VERDICT_TIMED_OUT;
                                res.expired     = 1'b1;
                            end
                            else
                            begin
                                if (itm.goal_met)
                                begin
                                    if (!st.steady_active)
                                    begin
                                        st_next.steady_active      = 1'b1;
                                        st_next.steady_start_stamp = itm.now_time;
                                        st_next.steady_elapsed     = '0;
                                        res.steady_began           = 1'b1;
                                    end
                                    else
                                    begin
                                        st_next.steady_elapsed = since_steady;
                                    end
                                end
                                else if (st.steady_active)
                                begin
                                    st_next.steady_active      = 1'b0;
                                    st_next.steady_start_stamp = '0;
                                    st_next.steady_elapsed     = '0;
                                    res.steady_lost            = 1'b1;
                                end
                                res.steady_time = st_next.steady_elapsed;

                                if (st.assist_phase == PH_HELD
                                    && since_press >= cfg_val.assist_hold)
                                begin
                                    st_next.assist_phase = PH_RELEASED;
                                    res.release_now      = 1'b1;
                                end
                                if (st.assist_phase == PH_ARMED && !itm.goal_met
                                    && itm.assist_wanted)
                                begin
                                    st_next.assist_phase = PH_HELD;
                                    st_next.press_stamp  = itm.now_time;
                                    res.press_now        = 1'b1;
                                end

                                if (st_next.steady_active
                                    && st_next.steady_elapsed >= cfg_val.stable_required
                                    && st_next.assist_phase != PH_HELD)
                                begin
                                    st_next.verdict = VERDICT_SATISFIED;
                                    res.done_ok     = 1'b1;
                                end
                            end
                        end

                        default:
                        begin
                            st_next = st;
                        end
                    endcase
                end
            end

            KIND_FORCE_RELEASE:
            begin
                if (st.assist_phase == PH_HELD)
                begin
                    st_next.assist_phase    = PH_RELEASED;
                    res.forced_release_done = 1'b1;
                end
            end

            default:
            begin
                st_next = st;
            end
        endcase

        res.assist_held_now  = (st_next.assist_phase == PH_HELD);
        res.assist_ever_used = (st_next.assist_phase == PH_HELD)
                               || (st_next.assist_phase == PH_RELEASED);
    end

endmodule

@@ src/stability_timeout_assist_fsm.sv @@
// ----------------------------------------------------------------------------
// Stability timeout assist FSM
// Supervises one transition: stability window, timed assist press, timeout.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle when the result side is not stalled
// and returns exactly one result per item: the item lands in an input register,
// a single pass of 32-bit subtract and compare logic works out the result and
// the next supervisor state, and both are stored as the item moves on to the
// result register. The state update sits inside that one pass, so consecutive
// items see each other's effect with no gap; if not stalled, the sustained rate
// is one item per cycle. The result register and the input register part the
// two sides: a new item is taken while a result waits, and back pressure on
// results stalls the input only once both registers are full. Register writes
// are taken in any cycle; write them only while no item is in flight. The
// configuration check is registered, so an item may follow a write in the next
// cycle. A start item clears the state and arms only with a valid setup; kind 3
// leaves the state alone and returns the held and used flags alone.
module stability_timeout_assist_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    stafsm_item_if.sink            item,
    stafsm_result_if.source        result,
    stafsm_cfg_if.sink             cfg
);
    import stafsm_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_ok_reg;

    logic       in_valid_reg;
    item_t      in_item_reg;

    logic       out_valid_reg;
    result_t    out_result_reg;

    sup_state_t state_reg;
    sup_state_t state_next;
    result_t    result_next;

    logic       advance;
    logic       in_fire;

    // Register writes: always ready, unknown indexes drop silently
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TIMEOUT_LIMIT:   cfg_reg.timeout_limit   <= cfg.data;
                REG_STABLE_REQUIRED: cfg_reg.stable_required <= cfg.data;
                REG_ASSIST_ON:       cfg_reg.assist_on       <= cfg.data[0];
                REG_ASSIST_HOLD:     cfg_reg.assist_hold     <= cfg.data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Hold the setup check in a register to keep compares off the item path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ok_reg <= cfg_is_valid(CFG_RESET);
        end
        else
        begin
            cfg_ok_reg <= cfg_is_valid(cfg_reg);
        end
    end

    // Advance the input register into the result register when the latter
    // is empty or its result transfers this cycle
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign in_fire    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg.kind          <= item.kind;
            in_item_reg.now_time      <= item.now_time;
            in_item_reg.goal_met      <= item.goal_met;
            in_item_reg.assist_wanted <= item.assist_wanted;
        end
    end

    stafsm_step u_step (
        .st      (state_reg),
        .cfg_val (cfg_reg),
        .cfg_ok  (cfg_ok_reg),
        .itm     (in_item_reg),
        .st_next (state_next),
        .res     (result_next)
    );

    // Supervisor state: commit only when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SUP_STATE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.bad_setup           = out_result_reg.bad_setup;
    assign result.done_ok             = out_result_reg.done_ok;
    assign result.expired             = out_result_reg.expired;
    assign result.steady_time         = out_result_reg.steady_time;
    assign result.steady_began        = out_result_reg.steady_began;
    assign result.steady_lost         = out_result_reg.steady_lost;
    assign result.press_now           = out_result_reg.press_now;
    assign result.release_now         = out_result_reg.release_now;
    assign result.assist_held_now     = out_result_reg.assist_held_now;
    assign result.assist_ever_used    = out_result_reg.assist_ever_used;
    assign result.forced_release_done = out_result_reg.forced_release_done;

endmodule

@@ src/stafsm_checker.sv @@
// ----------------------------------------------------------------------------
// Stability timeout assist FSM checker
// Port-level checks on results, bound to the supervisor top level.
// ----------------------------------------------------------------------------
`include "stability_timeout_assist_fsm_defines.svh"

module stafsm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      bad_setup,
    input logic                      done_ok,
    input logic                      expired,
    input logic [stafsm_pkg::TIME_W-1:0] steady_time,
    input logic                      press_now,
    input logic                      assist_held_now,
    input logic                      assist_ever_used,
    input logic                      forced_release_done
);
    import stafsm_pkg::*;

    // No result is offered while reset is asserted
    `STAFSM_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !out_valid, "result valid during reset")

    // A stalled result holds until it transfers
    `STAFSM_ASSERT(a_result_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(steady_time) && $stable(done_ok) && $stable(expired), "stalled result changed")

    // At most one of refusal, satisfied and timed out per result
    `STAFSM_ASSERT(a_verdict_exclusive, clk, rst_n, out_valid |-> $onehot0({bad_setup, done_ok, expired}), "conflicting verdict flags")

    // A held assist always counts as used, and a new press leaves it held
    `STAFSM_ASSERT(a_held_implies_used, clk, rst_n, out_valid && (assist_held_now || press_now) |-> assist_ever_used && assist_held_now == (assist_held_now || press_now), "held assist not marked used")

    // A forced release leaves nothing held
    `STAFSM_ASSERT(a_forced_release_drops, clk, rst_n, out_valid && forced_release_done |-> !assist_held_now && assist_ever_used && !press_now, "forced release left assist held")

endmodule

bind stability_timeout_assist_fsm stafsm_checker u_stafsm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (result.valid),
    .out_ready           (result.ready),
    .bad_setup           (result.bad_setup),
    .done_ok             (result.done_ok),
    .expired             (result.expired),
    .steady_time         (result.steady_time),
    .press_now           (result.press_now),
    .assist_held_now     (result.assist_held_now),
    .assist_ever_used    (result.assist_ever_used),
    .forced_release_done (result.forced_release_done)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stability timeout assist FSM testbench
// Drives start, tick, force-release and unused items through the supervisor,
// rewrites the setup registers between idle phases and checks every result
// against a cycle-free prediction of the supervisor state machine.
// ----------------------------------------------------------------------------
module testbench;
    import stafsm_pkg::*;

    // Unused item kind and an unmapped register index; the block ignores both.
    localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 8'hFC;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int TARGET_ITEMS   = 1330;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_OFF_AT    = 400;
    localparam int HOLD_OFF_LEN   = 64;
    localparam int QUIET_FROM     = 500;
    localparam int QUIET_TO       = 750;
    localparam int IDLE_PERCENT   = 12;

    // ------------------------------------------------------------------------
    // Transition scoreboard: keeps its own copy of the setup registers and the
    // supervisor state, predicts one result per accepted item and queues it.
    // ------------------------------------------------------------------------
    class transition_scoreboard;
        cfg_t       setup;
        sup_state_t st;
        result_t    pending_results[$];
        int         accepted;
        int         mismatches;

        function new();
            setup.timeout_limit   = 32'd10000;
            setup.stable_required = 32'd500;
            setup.assist_on       = 1'b0;
            setup.assist_hold     = 32'd0;
            st                    = '0;
            accepted              = 0;
            mismatches            = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TIMEOUT_LIMIT:   setup.timeout_limit   = val;
                REG_STABLE_REQUIRED: setup.stable_required = val;
                REG_ASSIST_ON:       setup.assist_on       = val[0];
                REG_ASSIST_HOLD:     setup.assist_hold     = val;
                default: ;
            endcase
        endfunction

        function bit setup_ok();
            if (setup.timeout_limit == 0 || setup.stable_required >= setup.timeout_limit)
                return 1'b0;
            if (setup.assist_on)
                return setup.stable_required != 0 && setup.assist_hold != 0
                       && setup.assist_hold < setup.timeout_limit;
            return setup.assist_hold == 0;
        endfunction

        function bit verdict_reached();
            return st.verdict != VERDICT_ACTIVE;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // One tick of the supervisor: timeout first, then the stability window,
        // the timed release, the press and finally the satisfied verdict.
        function void advance_tick(input item_t it, inout result_t r);
            logic [TIME_W-1:0] since;
            if (!st.armed || !setup_ok())
            begin
                r.bad_setup = 1'b1;
                return;
            end
            if (st.verdict == VERDICT_SATISFIED)
            begin
                r.done_ok     = 1'b1;
                r.steady_time = st.steady_elapsed;
                return;
            end
            if (st.verdict == VERDICT_TIMED_OUT)
            begin
                r.expired     = 1'b1;
                r.steady_time = st.steady_elapsed;
                return;
            end
            if (st.steady_active)
                st.steady_elapsed = it.now_time - st.steady_start_stamp;
            r.steady_time = st.steady_elapsed;
            since = it.now_time - st.start_stamp;
            if (since >= setup.timeout_limit)
            begin
                if (st.assist_phase == PH_HELD)
                begin
                    st.assist_phase = PH_RELEASED;
                    r.release_now   = 1'b1;
                end
                st.verdict = VERDICT_TIMED_OUT;
                r.expired  = 1'b1;
                return;
            end
            if (it.goal_met)
            begin
                if (!st.steady_active)
                begin
                    st.steady_active      = 1'b1;
                    st.steady_start_stamp = it.now_time;
                    st.steady_elapsed     = '0;
                    r.steady_began        = 1'b1;
                end
            end
            else if (st.steady_active)
            begin
                st.steady_active      = 1'b0;
                st.steady_start_stamp = '0;
                st.steady_elapsed     = '0;
                r.steady_lost         = 1'b1;
            end
            if (st.steady_active)
                st.steady_elapsed = it.now_time - st.steady_start_stamp;
            r.steady_time = st.steady_elapsed;
            since = it.now_time - st.press_stamp;
            if (st.assist_phase == PH_HELD && since >= setup.assist_hold)
            begin
                st.assist_phase = PH_RELEASED;
                r.release_now   = 1'b1;
            end
            if (st.assist_phase == PH_ARMED && !it.goal_met && it.assist_wanted)
            begin
                st.assist_phase = PH_HELD;
                st.press_stamp  = it.now_time;
                r.press_now     = 1'b1;
            end
            if (st.steady_active && st.steady_elapsed >= setup.stable_required
                && st.assist_phase != PH_HELD)
            begin
                st.verdict = VERDICT_SATISFIED;
                r.done_ok  = 1'b1;
            end
        endfunction

        function void note_item(input item_t it);
            result_t r;
            r = '0;
            accepted++;
            case (it.kind)
                KIND_START:
                begin
                    st = '0;
                    if (setup_ok())
                    begin
                        st.armed        = 1'b1;
                        st.start_stamp  = it.now_time;
                        st.assist_phase = setup.assist_on ? PH_ARMED : PH_DISABLED;
                        st.verdict      = VERDICT_ACTIVE;
                    end
                end
                KIND_TICK:
                    advance_tick(it, r);
                KIND_FORCE_RELEASE:
                begin
                    if (st.assist_phase == PH_HELD)
                    begin
                        st.assist_phase       = PH_RELEASED;
                        r.forced_release_done = 1'b1;
                    end
                end
                default: ;
            endcase
            r.assist_held_now  = st.assist_phase == PH_HELD;
            r.assist_ever_used = st.assist_phase == PH_HELD || st.assist_phase == PH_RELEASED;
            pending_results.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [TIME_W-1:0] want,
                                    input logic [TIME_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_flag(input string name, input logic want, input logic got);
            if (want !== got)
            begin
                $error("%s: expected %0b, got %0b", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no result expected");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_flag("bad_setup",           want.bad_setup,           got.bad_setup);
            compare_flag("done_ok",             want.done_ok,             got.done_ok);
            compare_flag("expired",             want.expired,             got.expired);
            compare_field("steady_time",        want.steady_time,         got.steady_time);
            compare_flag("steady_began",        want.steady_began,        got.steady_began);
            compare_flag("steady_lost",         want.steady_lost,         got.steady_lost);
            compare_flag("press_now",           want.press_now,           got.press_now);
            compare_flag("release_now",         want.release_now,         got.release_now);
            compare_flag("assist_held_now",     want.assist_held_now,     got.assist_held_now);
            compare_flag("assist_ever_used",    want.assist_ever_used,    got.assist_ever_used);
            compare_flag("forced_release_done", want.forced_release_done,
                         got.forced_release_done);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   hold_left   = 0;
    bit   held_off    = 1'b0;

    transition_scoreboard sb = new();

    stafsm_item_if   item_ch ();
    stafsm_result_if res_ch ();
    stafsm_cfg_if    cfg_ch ();

    stability_timeout_assist_fsm dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Kill the run if the handshakes stop moving.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // No idling on either side inside this window of accepted items.
    function automatic bit quiet_window();
        return sb.accepted >= QUIET_FROM && sb.accepted < QUIET_TO;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check each transfer, then pick ready for the next edge.
    // Once, after enough items, hold ready low for a long stretch so the two
    // internal registers fill up and the item channel stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        result_t got;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.bad_setup           = res_ch.bad_setup;
                got.done_ok             = res_ch.done_ok;
                got.expired             = res_ch.expired;
                got.steady_time         = res_ch.steady_time;
                got.steady_began        = res_ch.steady_began;
                got.steady_lost         = res_ch.steady_lost;
                got.press_now           = res_ch.press_now;
                got.release_now         = res_ch.release_now;
                got.assist_held_now     = res_ch.assist_held_now;
                got.assist_ever_used    = res_ch.assist_ever_used;
                got.forced_release_done = res_ch.forced_release_done;
                sb.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!held_off && sb.accepted >= HOLD_OFF_AT)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_OFF_LEN;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= quiet_window() || $urandom_range(0, 99) >= IDLE_PERCENT;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item and register drivers
    // ------------------------------------------------------------------------
    function automatic item_t make_item(input logic [KIND_W-1:0] kind,
                                        input logic [TIME_W-1:0] now,
                                        input logic goal, input logic want);
        item_t it;
        it.kind          = kind;
        it.now_time      = now;
        it.goal_met      = goal;
        it.assist_wanted = want;
        return it;
    endfunction

    // Offer one item and hold it until the transfer; valid stays high on
    // return so back-to-back items drop it only for a random idle gap.
    task automatic send(input item_t it);
        if (!quiet_window() && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= it.kind;
        item_ch.now_time      <= it.now_time;
        item_ch.goal_met      <= it.goal_met;
        item_ch.assist_wanted <= it.assist_wanted;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_item(it);
    endtask

    // Drop the item channel and wait until every queued result has come back.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, val);
    endtask

    // Reprogram all registers while the block is idle. The enable register
    // gets random upper bits, which the block must ignore, and the spare
    // index is written too.
    task automatic program_setup(input cfg_t c);
        settle();
        put_reg(REG_TIMEOUT_LIMIT,   c.timeout_limit);
        put_reg(REG_STABLE_REQUIRED, c.stable_required);
        put_reg(REG_ASSIST_ON,       ($urandom & 32'hFFFF_FFFE) | {31'd0, c.assist_on});
        put_reg(REG_ASSIST_HOLD,     c.assist_hold);
        put_reg(REG_SPARE,           $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    // Pick a setup: mostly valid ones, some at the range limits, some broken
    // in each of the ways the validity rule names.
    function automatic cfg_t pick_setup();
        cfg_t c;
        int   pick;
        c.timeout_limit   = $urandom_range(50, 3000);
        c.assist_on       = 1'b0;
        c.assist_hold     = '0;
        c.stable_required = $urandom_range(0, c.timeout_limit - 1);
        pick = $urandom_range(0, 6);
        case (pick)
            0, 1: ;
            2, 3:
            begin
                c.assist_on       = 1'b1;
                c.stable_required = $urandom_range(1, c.timeout_limit - 1);
                c.assist_hold     = $urandom_range(1, c.timeout_limit - 1);
            end
            4:
            begin
                c.timeout_limit   = 32'hFFFF_FFFF;
                c.assist_on       = 1'b1;
                c.stable_required = $urandom_range(0, 1) ? 32'hFFFF_FFFE
                                                         : $urandom_range(1, 800);
                c.assist_hold     = $urandom_range(0, 1) ? 32'hFFFF_FFFE
                                                         : $urandom_range(1, 600);
            end
            5:
            begin
                // Smallest legal setups: a one-millisecond timeout without assist, or the smallest with assist.
                if ($urandom_range(0, 1))
                begin
                    c.timeout_limit   = 32'd1;
                    c.stable_required = 32'd0;
                end
                else
                begin
                    c.timeout_limit   = 32'd2;
                    c.stable_required = 32'd1;
                    c.assist_on       = 1'b1;
                    c.assist_hold     = 32'd1;
                end
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: c.timeout_limit = '0;
                    1: c.stable_required = c.timeout_limit + $urandom_range(0, 3);
                    2:
                    begin
                        c.assist_on       = 1'b1;
                        c.stable_required = '0;
                        c.assist_hold     = $urandom_range(1, 40);
                    end
                    3:
                    begin
                        c.assist_on   = 1'b1;
                        c.assist_hold = '0;
                    end
                    4:
                    begin
                        c.assist_on       = 1'b1;
                        c.stable_required = $urandom_range(1, c.timeout_limit - 1);
                        c.assist_hold     = c.timeout_limit + $urandom_range(0, 3);
                    end
                    default: c.assist_hold = $urandom_range(1, 32'hFFFF_FFFF);
                endcase
            end
        endcase
        return c;
    endfunction

    // One supervised transition: usually a start, then ticks with advancing
    // time and a per-transition goal bias, sprinkled with force releases,
    // unused kinds, restarts and out-of-order timestamps. Stop a few items
    // after a verdict lands.
    task automatic run_transition();
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] stamp;
        int unsigned       span;
        int                steps;
        int                bias;
        int                tail;
        int                pick;
        item_t             it;
        t     = $urandom;
        bias  = $urandom_range(55, 97);
        steps = $urandom_range(4, 40);
        tail  = 0;
        if (sb.setup.timeout_limit == 0 || sb.setup.timeout_limit > 4000)
            span = 400;
        else
            span = sb.setup.timeout_limit / 5 + 1;
        if ($urandom_range(0, 9) != 0)
            send(make_item(KIND_START, t, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))));
        repeat (steps)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                it = make_item(KIND_FORCE_RELEASE, $urandom, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            else if (pick < 6)
                it = make_item(KIND_UNUSED, $urandom, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            else if (pick < 8)
                it = make_item(KIND_START, t, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    t = t + $urandom;
                else
                    t = t + $urandom_range(0, span);
                stamp = (pick < 11) ? $urandom : t;
                it = make_item(KIND_TICK, stamp, $urandom_range(0, 99) < bias,
                               1'($urandom_range(0, 1)));
            end
            send(it);
            if (sb.verdict_reached())
                tail++;
            if (tail > 2)
                break;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t c;
        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.kind          <= KIND_START;
        item_ch.now_time      <= '0;
        item_ch.goal_met      <= 1'b0;
        item_ch.assist_wanted <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_TIMEOUT_LIMIT;
        cfg_ch.data           <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup: 10000 ms timeout, 500 ms stability, no assist.
        // Tick before any start is refused; force release and the unused
        // kind only report the held and used flags.
        send(make_item(KIND_TICK, 32'd0, 1'b1, 1'b1));
        send(make_item(KIND_FORCE_RELEASE, 32'd0, 1'b0, 1'b0));
        send(make_item(KIND_UNUSED, $urandom, 1'b1, 1'b1));
        // Arm just below the wrap point and let the window cross zero.
        send(make_item(KIND_START, 32'hFFFF_FF00, 1'b0, 1'b0));
        send(make_item(KIND_TICK, 32'hFFFF_FF10, 1'b1, 1'b0));
        send(make_item(KIND_TICK, 32'h0000_0010, 1'b1, 1'b0));
        send(make_item(KIND_TICK, 32'h0000_0020, 1'b0, 1'b0));
        send(make_item(KIND_TICK, 32'h0000_0030, 1'b1, 1'b0));
        send(make_item(KIND_TICK, 32'h0000_0030 + 32'd500, 1'b1, 1'b0));
        send(make_item(KIND_TICK, 32'h0000_0300, 1'b0, 1'b1));
        // Timeout lands exactly at the deadline, then repeats.
        send(make_item(KIND_START, 32'd0, 1'b0, 1'b0));
        send(make_item(KIND_TICK, 32'd9999, 1'b0, 1'b1));
        send(make_item(KIND_TICK, 32'd10000, 1'b1, 1'b0));
        send(make_item(KIND_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1));

        // Assist on: press, timed release, then satisfied in the same tick.
        c.timeout_limit   = 32'd1000;
        c.stable_required = 32'd100;
        c.assist_on       = 1'b1;
        c.assist_hold     = 32'd200;
        program_setup(c);
        send(make_item(KIND_START, 32'd5000, 1'b0, 1'b0));
        send(make_item(KIND_TICK, 32'd5010, 1'b0, 1'b1));
        send(make_item(KIND_TICK, 32'd5100, 1'b1, 1'b0));
        send(make_item(KIND_TICK, 32'd5210, 1'b1, 1'b0));
        // Force release drops a held press once; a released assist never
        // presses again.
        send(make_item(KIND_START, 32'd0, 1'b0, 1'b0));
        send(make_item(KIND_TICK, 32'd10, 1'b0, 1'b1));
        send(make_item(KIND_FORCE_RELEASE, 32'd11, 1'b0, 1'b0));
        send(make_item(KIND_FORCE_RELEASE, 32'd12, 1'b1, 1'b1));
        send(make_item(KIND_TICK, 32'd20, 1'b0, 1'b1));
        // Timeout while the press is held releases it.
        send(make_item(KIND_START, 32'd0, 1'b0, 1'b0));
        send(make_item(KIND_TICK, 32'd10, 1'b0, 1'b1));
        send(make_item(KIND_TICK, 32'd1000, 1'b1, 1'b0));

        // Random transitions; reprogram now and then, but not while the
        // result side is in its long hold-off or about to start it, so items
        // keep coming while results are held back.
        while (sb.accepted < TARGET_ITEMS)
        begin
            if (hold_left == 0 && (held_off || sb.accepted + 50 < HOLD_OFF_AT)
                && $urandom_range(0, 2) == 0)
                program_setup(pick_setup());
            run_transition();
        end

        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
